// ----- rtl/core/lsc_pkg.sv -----
// Shared types, constants and the arctangent table for the lidar point converter.
// No dependencies; used by every module under rtl/core.
package lsc_pkg;

    localparam int MAX_COLUMNS_DEF  = 2048;
    localparam int MAX_ROWS_DEF     = 128;
    localparam int CORDIC_STEPS_DEF = 20;

    localparam int ANGLE_W   = 32;
    localparam int RANGE_W   = 32;
    localparam int COORD_W   = 33;
    localparam int TRIG_W    = 32;   // clamped sine/cosine, Q2.30 in [-1, 1]
    localparam int CORD_W    = 34;   // CORDIC working width
    localparam int PROD_W    = COORD_W + TRIG_W;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int COLS_W    = 12;
    localparam int ROWS_W    = 8;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 104;

    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CORD_W-1:0] ONE_Q30     = 34'sd1073741824;

    // register indexes
    localparam logic [2:0] REG_H_START = 3'd0;
    localparam logic [2:0] REG_H_STEP  = 3'd1;
    localparam logic [2:0] REG_V_START = 3'd2;
    localparam logic [2:0] REG_V_STEP  = 3'd3;
    localparam logic [2:0] REG_COLS    = 3'd4;
    localparam logic [2:0] REG_ROWS    = 3'd5;
    localparam logic [2:0] REG_MIN_RNG = 3'd6;
    localparam logic [2:0] REG_MAX_RNG = 3'd7;

    typedef struct packed {
        logic [ANGLE_W-1:0] h_start;
        logic [ANGLE_W-1:0] h_step;
        logic [ANGLE_W-1:0] v_start;
        logic [ANGLE_W-1:0] v_step;
        logic [COLS_W-1:0]  cols;
        logic [ROWS_W-1:0]  rows;
        logic [RANGE_W-1:0] min_range;
        logic [RANGE_W-1:0] max_range;
    } cfg_t;

    typedef enum logic [1:0] {
        MUL_R_SV  = 2'd0,
        MUL_R_CV  = 2'd1,
        MUL_RC_CH = 2'd2,
        MUL_RC_SH = 2'd3
    } mul_op_t;

    typedef struct packed {
        logic    accept;
        logic    cordic_start;
        logic    mul_en;
        mul_op_t mul_op;
        logic    wr_pz;
        logic    wr_rc;
        logic    wr_px;
        logic    wr_py;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic cordic_done;
        logic out_free;
    } sts_t;

    // atan(2^-i) in turns scaled by 2^32
    function automatic logic [29:0] atan_lookup(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/lidar_spherical_to_cartesian_top.sv -----
// Top level of the lidar spherical-to-Cartesian point converter.
// Depends on lsc_pkg, lsc_regs, lsc_ctrl, lsc_datapath (and lsc_cordic below it).
//
//  port group   direction  fields (low bit first)
//  s_*          in         tdata: range_value[31:0]; tuser: scan_start
//  m_*          out        tdata: point_x[32:0], point_y[65:33], point_z[98:66];
//                          tuser: point_valid; tlast: scan_last
//  p*           in/out     APB config, registers at byte address 4*index
//
//  Each item runs through the iterative CORDIC units (one step a cycle) and
//  four passes through the shared multiplier. One item is in work at a time;
//  the next is taken as soon as the previous result sits in the output
//  register.
//  Reset is synchronous, active low, and clears counters, FSM and output valid.
//  A stalled m_tready holds the result; the block stops before loading the next.
module lidar_spherical_to_cartesian_top #(
    parameter int MAX_COLUMNS  = lsc_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS     = lsc_pkg::MAX_ROWS_DEF,
    parameter int CORDIC_STEPS = lsc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lsc_pkg::S_TDATA_W-1:0]  s_tdata,   // range_value
    input  logic [0:0]                     s_tuser,   // scan_start
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lsc_pkg::M_TDATA_W-1:0]  m_tdata,   // point_x, point_y, point_z, pad
    output logic [0:0]                     m_tuser,   // point_valid
    output logic                           m_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lsc_pkg::ADDR_W-1:0]     paddr,
    input  logic [lsc_pkg::DATA_W-1:0]     pwdata,
    output logic [lsc_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    lsc_pkg::cfg_t cfg;
    lsc_pkg::cmd_t cmd;
    lsc_pkg::sts_t sts;

    lsc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lsc_datapath #(
        .MAX_COLUMNS  (MAX_COLUMNS),
        .MAX_ROWS     (MAX_ROWS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- rtl/core/lsc_regs.sv -----
// APB-style configuration register file for the point converter.
// Depends on lsc_pkg (cfg_t, register indexes).
module lsc_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lsc_pkg::ADDR_W-1:0]  paddr,
    input  logic [lsc_pkg::DATA_W-1:0]  pwdata,
    output logic [lsc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output lsc_pkg::cfg_t               cfg
);

    lsc_pkg::cfg_t cfg_reg;
    logic [2:0]    idx;
    logic          wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.h_start   <= '0;
            cfg_reg.h_step    <= '0;
            cfg_reg.v_start   <= '0;
            cfg_reg.v_step    <= '0;
            cfg_reg.cols      <= lsc_pkg::COLS_W'(1);
            cfg_reg.rows      <= lsc_pkg::ROWS_W'(1);
            cfg_reg.min_range <= '0;
            cfg_reg.max_range <= '1;
        end else if (wr_en) begin
            unique case (idx)
                lsc_pkg::REG_H_START: cfg_reg.h_start   <= pwdata;
                lsc_pkg::REG_H_STEP:  cfg_reg.h_step    <= pwdata;
                lsc_pkg::REG_V_START: cfg_reg.v_start   <= pwdata;
                lsc_pkg::REG_V_STEP:  cfg_reg.v_step    <= pwdata;
                lsc_pkg::REG_COLS:    cfg_reg.cols      <= pwdata[lsc_pkg::COLS_W-1:0];
                lsc_pkg::REG_ROWS:    cfg_reg.rows      <= pwdata[lsc_pkg::ROWS_W-1:0];
                lsc_pkg::REG_MIN_RNG: cfg_reg.min_range <= pwdata;
                lsc_pkg::REG_MAX_RNG: cfg_reg.max_range <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            lsc_pkg::REG_H_START: prdata = cfg_reg.h_start;
            lsc_pkg::REG_H_STEP:  prdata = cfg_reg.h_step;
            lsc_pkg::REG_V_START: prdata = cfg_reg.v_start;
            lsc_pkg::REG_V_STEP:  prdata = cfg_reg.v_step;
            lsc_pkg::REG_COLS:    prdata = lsc_pkg::DATA_W'(cfg_reg.cols);
            lsc_pkg::REG_ROWS:    prdata = lsc_pkg::DATA_W'(cfg_reg.rows);
            lsc_pkg::REG_MIN_RNG: prdata = cfg_reg.min_range;
            lsc_pkg::REG_MAX_RNG: prdata = cfg_reg.max_range;
            default:              prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/lsc_cordic.sv -----
// Iterative rotation CORDIC: sine and cosine of a binary angle, one step per cycle.
// Depends on lsc_pkg (widths, gain, atan_lookup).
module lsc_cordic #(
    parameter int STEPS = lsc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [lsc_pkg::ANGLE_W-1:0]        angle,
    output logic                               done,
    output logic signed [lsc_pkg::TRIG_W-1:0]  sin_out,
    output logic signed [lsc_pkg::TRIG_W-1:0]  cos_out
);

    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int W     = lsc_pkg::CORD_W;

    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg, done_reg, flip_reg;
    logic signed [W-1:0] x_reg, y_reg, z_reg;
    logic signed [lsc_pkg::TRIG_W-1:0] sin_reg, cos_reg;

    logic                flip;
    logic [4:0]          step_idx;
    logic signed [W-1:0] dx, dy, atan_s, x_cl, y_cl;

    // fold to [-pi/2, pi/2): subtracting a half turn just flips the top bit
    assign flip     = angle[31] ^ angle[30];
    assign step_idx = 5'(cnt_reg);
    assign dx       = y_reg >>> step_idx;
    assign dy       = x_reg >>> step_idx;
    assign atan_s   = $signed(W'(lsc_pkg::atan_lookup(step_idx)));

    always_comb begin
        if (x_reg > lsc_pkg::ONE_Q30)       x_cl = lsc_pkg::ONE_Q30;
        else if (x_reg < -lsc_pkg::ONE_Q30) x_cl = -lsc_pkg::ONE_Q30;
        else                                x_cl = x_reg;
        if (y_reg > lsc_pkg::ONE_Q30)       y_cl = lsc_pkg::ONE_Q30;
        else if (y_reg < -lsc_pkg::ONE_Q30) y_cl = -lsc_pkg::ONE_Q30;
        else                                y_cl = y_reg;
        if (flip_reg) begin
            x_cl = -x_cl;
            y_cl = -y_cl;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            if (cnt_reg == CNT_W'(STEPS)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            flip_reg <= flip;
            x_reg    <= lsc_pkg::CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= W'($signed({angle[31] ^ flip, angle[30:0]}));
        end else if (busy_reg) begin
            if (cnt_reg == CNT_W'(STEPS)) begin
                sin_reg <= y_cl[lsc_pkg::TRIG_W-1:0];
                cos_reg <= x_cl[lsc_pkg::TRIG_W-1:0];
            end else if (!z_reg[W-1]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_s;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_s;
            end
        end
    end

    assign done    = done_reg;
    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

// ----- rtl/core/lsc_datapath.sv -----
// Datapath: grid counters, angle accumulators, two CORDIC units, one shared
// multiplier and the output register. Depends on lsc_pkg and lsc_cordic.
module lsc_datapath #(
    parameter int MAX_COLUMNS  = lsc_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS     = lsc_pkg::MAX_ROWS_DEF,
    parameter int CORDIC_STEPS = lsc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lsc_pkg::cfg_t                  cfg,
    input  lsc_pkg::cmd_t                  cmd,
    output lsc_pkg::sts_t                  sts,
    input  logic [lsc_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lsc_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [0:0]                     m_tuser,
    output logic                           m_tlast
);

    localparam int CIW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CCW_N = $clog2(MAX_COLUMNS + 1);
    localparam int RCW_N = $clog2(MAX_ROWS + 1);
    localparam int CCW   = (CCW_N > lsc_pkg::COLS_W) ? CCW_N : lsc_pkg::COLS_W;
    localparam int RCW   = (RCW_N > lsc_pkg::ROWS_W) ? RCW_N : lsc_pkg::ROWS_W;
    localparam int CW    = lsc_pkg::COORD_W;
    localparam int AW    = lsc_pkg::ANGLE_W;

    // scan position state
    logic [CIW-1:0] col_reg;
    logic [RIW-1:0] row_reg;
    logic [AW-1:0]  h_now_reg, v_now_reg;

    // per-item latches
    logic [lsc_pkg::RANGE_W-1:0] r_reg;
    logic                        valid_reg, last_reg;
    logic [AW-1:0]               h_ang_reg, v_ang_reg;

    logic signed [lsc_pkg::PROD_W-1:0] prod_reg;
    logic signed [CW-1:0]              rc_reg, px_reg, py_reg, pz_reg;

    logic                 m_tvalid_reg, m_tlast_reg, m_valid_flag_reg;
    logic signed [CW-1:0] m_x_reg, m_y_reg, m_z_reg;

    logic [CCW-1:0] cols_c, col_last;
    logic [RCW-1:0] rows_c, row_last;
    logic [CIW-1:0] col_eff;
    logic [RIW-1:0] row_eff;
    logic [AW-1:0]  h_eff, v_eff;
    logic           row_end, grid_end, in_range;

    logic signed [lsc_pkg::TRIG_W-1:0] sin_h, cos_h, sin_v, cos_v;
    logic                              done_h, done_v;
    logic signed [CW-1:0]              mul_a;
    logic signed [lsc_pkg::TRIG_W-1:0] mul_b;
    logic signed [lsc_pkg::PROD_W-1:0] prod_rnd;
    logic signed [CW-1:0]              rnd;

    always_comb begin
        if (cfg.cols == '0)
            cols_c = CCW'(1);
        else if (CCW'(cfg.cols) > CCW'(MAX_COLUMNS))
            cols_c = CCW'(MAX_COLUMNS);
        else
            cols_c = CCW'(cfg.cols);
        if (cfg.rows == '0)
            rows_c = RCW'(1);
        else if (RCW'(cfg.rows) > RCW'(MAX_ROWS))
            rows_c = RCW'(MAX_ROWS);
        else
            rows_c = RCW'(cfg.rows);
    end

    assign col_last = cols_c - 1'b1;
    assign row_last = rows_c - 1'b1;

    // scan start restarts the grid before this item is converted
    assign col_eff  = s_tuser[0] ? '0 : col_reg;
    assign row_eff  = s_tuser[0] ? '0 : row_reg;
    assign h_eff    = s_tuser[0] ? cfg.h_start : h_now_reg;
    assign v_eff    = s_tuser[0] ? cfg.v_start : v_now_reg;
    // an index past a shrunken grid counts as the last position
    assign row_end  = CCW'(col_eff) >= col_last;
    assign grid_end = row_end && (RCW'(row_eff) >= row_last);
    assign in_range = (s_tdata >= cfg.min_range) && (s_tdata <= cfg.max_range);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            h_now_reg <= '0;
            v_now_reg <= '0;
        end else if (cmd.accept) begin
            if (row_end) begin
                col_reg   <= '0;
                h_now_reg <= cfg.h_start;
                if (grid_end) begin
                    row_reg   <= '0;
                    v_now_reg <= cfg.v_start;
                end else begin
                    row_reg   <= row_eff + 1'b1;
                    v_now_reg <= v_eff + cfg.v_step;
                end
            end else begin
                col_reg   <= col_eff + 1'b1;
                row_reg   <= row_eff;
                h_now_reg <= h_eff + cfg.h_step;
                v_now_reg <= v_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            r_reg     <= s_tdata;
            valid_reg <= in_range;
            last_reg  <= grid_end;
            h_ang_reg <= h_eff;
            v_ang_reg <= v_eff;
        end
    end

    lsc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_h (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.cordic_start),
        .angle   (h_ang_reg),
        .done    (done_h),
        .sin_out (sin_h),
        .cos_out (cos_h)
    );

    lsc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_v (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.cordic_start),
        .angle   (v_ang_reg),
        .done    (done_v),
        .sin_out (sin_v),
        .cos_out (cos_v)
    );

    // shared multiplier, operands picked by the controller
    always_comb begin
        unique case (cmd.mul_op)
            lsc_pkg::MUL_R_SV:  begin mul_a = $signed({1'b0, r_reg}); mul_b = sin_v; end
            lsc_pkg::MUL_R_CV:  begin mul_a = $signed({1'b0, r_reg}); mul_b = cos_v; end
            lsc_pkg::MUL_RC_CH: begin mul_a = rc_reg;                 mul_b = cos_h; end
            lsc_pkg::MUL_RC_SH: begin mul_a = rc_reg;                 mul_b = sin_h; end
            default:            begin mul_a = rc_reg;                 mul_b = sin_h; end
        endcase
    end

    // round to Q17.16: add half an LSB, arithmetic shift by 30
    assign prod_rnd = prod_reg + (lsc_pkg::PROD_W'(1) <<< 29);
    assign rnd      = prod_rnd[CW+29:30];

    always_ff @(posedge aclk) begin
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        if (cmd.wr_pz) pz_reg <= rnd;
        if (cmd.wr_rc) rc_reg <= rnd;
        if (cmd.wr_px) px_reg <= rnd;
        if (cmd.wr_py) py_reg <= rnd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_x_reg          <= valid_reg ? px_reg : '0;
            m_y_reg          <= valid_reg ? py_reg : '0;
            m_z_reg          <= valid_reg ? pz_reg : '0;
            m_valid_flag_reg <= valid_reg;
            m_tlast_reg      <= last_reg;
        end
    end

    assign sts.cordic_done = done_h & done_v;
    assign sts.out_free    = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_z_reg, m_y_reg, m_x_reg};
    assign m_tuser  = m_valid_flag_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ----- rtl/core/lsc_ctrl.sv -----
// Controller FSM: sequences accept, CORDIC run, the four shared multiplies and
// the output load. Depends on lsc_pkg (cmd_t, sts_t, mul_op_t).
module lsc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  lsc_pkg::sts_t  sts,
    output lsc_pkg::cmd_t  cmd
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_START  = 10'b0000000010,
        ST_CORDIC = 10'b0000000100,
        ST_MZ     = 10'b0000001000,
        ST_MC     = 10'b0000010000,
        ST_RC     = 10'b0000100000,
        ST_MX     = 10'b0001000000,
        ST_MY     = 10'b0010000000,
        ST_OUT    = 10'b0100000000,
        ST_LOAD   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = lsc_pkg::MUL_R_SV;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.cordic_start = 1'b1;
                state_next       = ST_CORDIC;
            end
            ST_CORDIC: begin
                if (sts.cordic_done) state_next = ST_MZ;
            end
            ST_MZ: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = lsc_pkg::MUL_R_SV;
                state_next = ST_MC;
            end
            ST_MC: begin
                cmd.wr_pz  = 1'b1;
                cmd.mul_en = 1'b1;
                cmd.mul_op = lsc_pkg::MUL_R_CV;
                state_next = ST_RC;
            end
            ST_RC: begin
                cmd.wr_rc  = 1'b1;
                state_next = ST_MX;
            end
            ST_MX: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = lsc_pkg::MUL_RC_CH;
                state_next = ST_MY;
            end
            ST_MY: begin
                cmd.wr_px  = 1'b1;
                cmd.mul_en = 1'b1;
                cmd.mul_op = lsc_pkg::MUL_RC_SH;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // y is rounded into its register here; the output register takes it in ST_LOAD
                cmd.wr_py  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                // load the output once y has been rounded into its register and the output is free
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- test/lsc_point_checker.sv -----
// Point checker for the lidar spherical-to-Cartesian converter: watches the APB
// writes and both stream channels, predicts each point and compares it.
// Depends on lsc_pkg for widths and register indexes.
`timescale 1ns / 100ps

module lsc_point_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [lsc_pkg::S_TDATA_W-1:0] s_tdata,   // range_value
    input  logic [0:0]                    s_tuser,   // scan_start
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [lsc_pkg::M_TDATA_W-1:0] m_tdata,   // point_x, point_y, point_z, pad
    input  logic [0:0]                    m_tuser,   // point_valid
    input  logic                          m_tlast,   // scan_last
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsc_pkg::ADDR_W-1:0]    paddr,
    input  logic [lsc_pkg::DATA_W-1:0]    pwdata,
    input  logic                          pready,
    output int                            mismatch_count,
    output int                            points_in_flight
);

    localparam longint GAIN_Q30   = 64'sd652032874;
    localparam longint UNITY_Q30  = 64'sd1073741824;
    localparam longint HALF_LSB   = 64'sd536870912;
    localparam int     ITERATIONS = lsc_pkg::CORDIC_STEPS_DEF;

    // arctangent of 2^-i as a fraction of a turn, scaled by 2^32
    localparam longint ATAN_TURNS [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1, 0
    };

    typedef struct packed {
        logic [lsc_pkg::COORD_W-1:0] x;
        logic [lsc_pkg::COORD_W-1:0] y;
        logic [lsc_pkg::COORD_W-1:0] z;
        logic                        valid;
        logic                        last;
    } point_t;

    logic [31:0]  h_start, h_step, v_start, v_step;
    logic [11:0]  cols_reg;
    logic [7:0]   rows_reg;
    logic [31:0]  min_rng, max_rng;
    int unsigned  col_idx, row_idx;
    logic [31:0]  h_now, v_now;
    point_t       queued_points [$];
    point_t       fresh_point, oldest_point, seen_point;

    function automatic void rotate_angle(input logic [31:0] angle,
                                         output longint sin_q30, output longint cos_q30);
        logic [31:0] shifted, folded;
        logic        flip;
        longint      cx, cy, cz, dx, dy;
        // fold into [-quarter, quarter) turn; the half-turn offset flips both signs
        shifted = angle + 32'h4000_0000;
        flip    = shifted[31];
        folded  = flip ? angle - 32'h8000_0000 : angle;
        cz      = longint'($signed(folded));
        cx      = GAIN_Q30;
        cy      = 0;
        for (int i = 0; i < ITERATIONS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cz >= 0) begin
                cx -= dx;
                cy += dy;
                cz -= ATAN_TURNS[i];
            end else begin
                cx += dx;
                cy -= dy;
                cz += ATAN_TURNS[i];
            end
        end
        if (cx > UNITY_Q30)  cx = UNITY_Q30;
        if (cx < -UNITY_Q30) cx = -UNITY_Q30;
        if (cy > UNITY_Q30)  cy = UNITY_Q30;
        if (cy < -UNITY_Q30) cy = -UNITY_Q30;
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end
        sin_q30 = cy;
        cos_q30 = cx;
    endfunction

    function automatic longint round_q30(input longint a, input longint b);
        return (a * b + HALF_LSB) >>> 30;
    endfunction

    task automatic convert_sample(input logic [31:0] range_q16, input logic scan_flag,
                                  output point_t pt);
        int unsigned cols, rows;
        logic        row_end, grid_end, in_limits;
        longint      sin_v, cos_v, sin_h, cos_h, r_cos_v, px, py, pz;
        cols = (cols_reg == 0) ? 1 :
               (cols_reg > lsc_pkg::MAX_COLUMNS_DEF) ? lsc_pkg::MAX_COLUMNS_DEF : cols_reg;
        rows = (rows_reg == 0) ? 1 :
               (rows_reg > lsc_pkg::MAX_ROWS_DEF) ? lsc_pkg::MAX_ROWS_DEF : rows_reg;
        if (scan_flag) begin
            col_idx = 0;
            row_idx = 0;
            h_now   = h_start;
            v_now   = v_start;
        end
        row_end   = col_idx >= cols - 1;
        grid_end  = row_end && (row_idx >= rows - 1);
        in_limits = (range_q16 >= min_rng) && (range_q16 <= max_rng);
        px = 0;
        py = 0;
        pz = 0;
        if (in_limits) begin
            rotate_angle(v_now, sin_v, cos_v);
            rotate_angle(h_now, sin_h, cos_h);
            r_cos_v = round_q30(longint'({32'h0, range_q16}), cos_v);
            pz      = round_q30(longint'({32'h0, range_q16}), sin_v);
            px      = round_q30(r_cos_v, cos_h);
            py      = round_q30(r_cos_v, sin_h);
        end
        pt.x     = px[lsc_pkg::COORD_W-1:0];
        pt.y     = py[lsc_pkg::COORD_W-1:0];
        pt.z     = pz[lsc_pkg::COORD_W-1:0];
        pt.valid = in_limits;
        pt.last  = grid_end;
        // a shrunken grid can leave the index past its end: treat that as the end
        if (row_end) begin
            col_idx = 0;
            h_now   = h_start;
            if (grid_end) begin
                row_idx = 0;
                v_now   = v_start;
            end else begin
                row_idx++;
                v_now += v_step;
            end
        end else begin
            col_idx++;
            h_now += h_step;
        end
    endtask

    task automatic compare_field(input string label,
                                 input logic [lsc_pkg::COORD_W-1:0] want,
                                 input logic [lsc_pkg::COORD_W-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("point mismatch %0d at %0t: %s expected %0d got %0d",
                         mismatch_count, $realtime, label, $signed(want), $signed(got));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            h_start = '0;
            h_step  = '0;
            v_start = '0;
            v_step  = '0;
            cols_reg = 12'd1;
            rows_reg = 8'd1;
            min_rng = '0;
            max_rng = '1;
            col_idx = 0;
            row_idx = 0;
            h_now   = '0;
            v_now   = '0;
            queued_points.delete();
            points_in_flight = 0;
            mismatch_count   = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    lsc_pkg::REG_H_START: h_start  = pwdata;
                    lsc_pkg::REG_H_STEP:  h_step   = pwdata;
                    lsc_pkg::REG_V_START: v_start  = pwdata;
                    lsc_pkg::REG_V_STEP:  v_step   = pwdata;
                    lsc_pkg::REG_COLS:    cols_reg = pwdata[11:0];
                    lsc_pkg::REG_ROWS:    rows_reg = pwdata[7:0];
                    lsc_pkg::REG_MIN_RNG: min_rng  = pwdata;
                    lsc_pkg::REG_MAX_RNG: max_rng  = pwdata;
                    default: ;
                endcase
            end
            // results first, so an item taken on the same edge cannot match them
            if (m_tvalid && m_tready) begin
                seen_point.x     = m_tdata[lsc_pkg::COORD_W-1:0];
                seen_point.y     = m_tdata[2*lsc_pkg::COORD_W-1:lsc_pkg::COORD_W];
                seen_point.z     = m_tdata[3*lsc_pkg::COORD_W-1:2*lsc_pkg::COORD_W];
                seen_point.valid = m_tuser[0];
                seen_point.last  = m_tlast;
                if (queued_points.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected point at %0t: x %0d y %0d z %0d valid %0b last %0b",
                                 $realtime, $signed(seen_point.x), $signed(seen_point.y),
                                 $signed(seen_point.z), seen_point.valid, seen_point.last);
                end else begin
                    oldest_point = queued_points.pop_front();
                    compare_field("x", oldest_point.x, seen_point.x);
                    compare_field("y", oldest_point.y, seen_point.y);
                    compare_field("z", oldest_point.z, seen_point.z);
                    compare_field("valid", {32'h0, oldest_point.valid}, {32'h0, seen_point.valid});
                    compare_field("last", {32'h0, oldest_point.last}, {32'h0, seen_point.last});
                end
            end
            if (s_tvalid && s_tready) begin
                convert_sample(s_tdata, s_tuser[0], fresh_point);
                queued_points = {queued_points, fresh_point};
            end
            points_in_flight = queued_points.size();
        end
    end

endmodule

// ----- test/tb_lidar_spherical_to_cartesian_top.sv -----
// Testbench top for the lidar point converter: clock, reset, APB set-up, range
// samples in bursts, a stalling receiver and the verdict.
// Depends on lsc_pkg, the RTL under rtl/core and lsc_point_checker.
`timescale 1ns / 100ps

module tb_lidar_spherical_to_cartesian_top;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_POINTS = 1550;
    localparam int DRAIN_CYCLES  = 40;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [lsc_pkg::S_TDATA_W-1:0] s_tdata;    // range_value
    logic [0:0]                    s_tuser;    // scan_start
    logic                          m_tvalid;
    logic                          m_tready;
    logic [lsc_pkg::M_TDATA_W-1:0] m_tdata;    // point_x, point_y, point_z, pad
    logic [0:0]                    m_tuser;    // point_valid
    logic                          m_tlast;    // scan_last
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [lsc_pkg::ADDR_W-1:0]    paddr;
    logic [lsc_pkg::DATA_W-1:0]    pwdata;
    logic [lsc_pkg::DATA_W-1:0]    prdata;
    logic                          pready;

    int                   mismatch_count;
    int                   points_in_flight;
    int                   points_sent;
    int                   cycle_count;

    // grid and limits as last written, for shaping the stimulus
    int                   grid_cols, grid_rows;
    logic [31:0]          min_set, max_set;

    lidar_spherical_to_cartesian_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    lsc_point_checker i_point_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .mismatch_count   (mismatch_count),
        .points_in_flight (points_in_flight)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // receiver: stretches of its own stall pattern, plus one long hold-off
    initial begin
        int stretch, mode;
        bit held;
        m_tready = 1'b0;
        held     = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (!held && points_sent >= 600) begin
                held = 1'b1;
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (500) @(negedge aclk);
            end
            stretch = $urandom_range(16, 96);
            mode    = $urandom_range(0, 3);
            repeat (stretch) begin
                @(negedge aclk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ~m_tready;
                endcase
            end
        end
    end

    function automatic int clamp_grid(input int value, input int top);
        return (value < 1) ? 1 : (value > top) ? top : value;
    endfunction

    function automatic logic [31:0] pick_angle();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'h4000_0000;
            3: return 32'hC000_0000;
            4: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        logic [31:0] mag;
        if ($urandom_range(0, 3) == 0)
            return pick_angle();
        mag = $urandom_range(0, 32'h0400_0000);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic logic [31:0] pick_range();
        case ($urandom_range(0, 9))
            0: return min_set;
            1: return max_set;
            2: return min_set - 1;
            3: return max_set + 1;
            4: return 32'h0000_0000;
            5: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_point(input logic [31:0] range_q16, input logic scan_flag);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= range_q16;
        s_tuser  <= scan_flag;
        do @(posedge aclk); while (!s_tready);
        points_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    // every result in, sender quiet: safe to touch the registers
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (points_in_flight == 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            lsc_pkg::REG_COLS:
                grid_cols = clamp_grid(int'(value[11:0]), lsc_pkg::MAX_COLUMNS_DEF);
            lsc_pkg::REG_ROWS:
                grid_rows = clamp_grid(int'(value[7:0]), lsc_pkg::MAX_ROWS_DEF);
            lsc_pkg::REG_MIN_RNG: min_set = value;
            lsc_pkg::REG_MAX_RNG: max_set = value;
            default: ;
        endcase
    endtask

    task automatic reconfigure();
        logic [31:0] word;
        logic [31:0] low_end;
        if ($urandom_range(0, 1)) write_reg(lsc_pkg::REG_H_START, pick_angle());
        if ($urandom_range(0, 1)) write_reg(lsc_pkg::REG_H_STEP, pick_step());
        if ($urandom_range(0, 1)) write_reg(lsc_pkg::REG_V_START, pick_angle());
        if ($urandom_range(0, 1)) write_reg(lsc_pkg::REG_V_STEP, pick_step());
        if ($urandom_range(0, 2) != 0) begin
            word = $urandom;   // junk above the field
            case ($urandom_range(0, 15))
                0: word[11:0] = 12'd0;
                1: word[11:0] = 12'd2048;
                2: word[11:0] = 12'hFFF;
                3: word[11:0] = 12'($urandom);
                default: word[11:0] = 12'($urandom_range(1, 12));
            endcase
            write_reg(lsc_pkg::REG_COLS, word);
        end
        if ($urandom_range(0, 2) != 0) begin
            word = $urandom;
            case ($urandom_range(0, 15))
                0: word[7:0] = 8'd0;
                1: word[7:0] = 8'd128;
                2: word[7:0] = 8'hFF;
                3: word[7:0] = 8'($urandom);
                default: word[7:0] = 8'($urandom_range(1, 5));
            endcase
            write_reg(lsc_pkg::REG_ROWS, word);
        end
        if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 9))
                0: begin
                    write_reg(lsc_pkg::REG_MIN_RNG, 32'h0000_0000);
                    write_reg(lsc_pkg::REG_MAX_RNG, 32'hFFFF_FFFF);
                end
                1: begin
                    low_end = $urandom_range(1, 32'hFFFF_FFFF);
                    write_reg(lsc_pkg::REG_MIN_RNG, low_end);
                    write_reg(lsc_pkg::REG_MAX_RNG, $urandom_range(0, low_end - 1));
                end
                2: begin
                    low_end = $urandom;
                    write_reg(lsc_pkg::REG_MIN_RNG, low_end);
                    write_reg(lsc_pkg::REG_MAX_RNG, low_end);
                end
                default: begin
                    write_reg(lsc_pkg::REG_MIN_RNG, $urandom_range(0, 32'h0002_0000));
                    write_reg(lsc_pkg::REG_MAX_RNG,
                              $urandom_range(32'h0100_0000, 32'hFFFF_FFFF));
                end
            endcase
        end
    endtask

    initial begin
        int          random_sent, burst_left, phase_len, grid_points, grid_pos;
        logic        scan_flag, well_formed;
        logic [31:0] dir_range [0:5];
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        aresetn     = 1'b0;
        points_sent = 0;
        grid_cols   = 1;
        grid_rows   = 1;
        min_set     = 32'h0000_0000;
        max_set     = 32'hFFFF_FFFF;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: a one-point grid, every range accepted
        send_point(32'hFFFF_FFFF, 1'b0);
        send_point(32'h0000_0000, 1'b1);

        // quadrant boundaries on both angles, range limits on a 4x3 grid
        drain();
        write_reg(lsc_pkg::REG_H_START, 32'h8000_0000);
        write_reg(lsc_pkg::REG_H_STEP,  32'h4000_0000);
        write_reg(lsc_pkg::REG_V_START, 32'hC000_0000);
        write_reg(lsc_pkg::REG_V_STEP,  32'h4000_0000);
        write_reg(lsc_pkg::REG_COLS,    32'd4);
        write_reg(lsc_pkg::REG_ROWS,    32'd3);
        write_reg(lsc_pkg::REG_MIN_RNG, 32'h0001_0000);
        write_reg(lsc_pkg::REG_MAX_RNG, 32'h7FFF_FFFF);
        dir_range = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h0000_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
        // restart mid-row, then run through the grid end and wrap
        for (int k = 0; k < 18; k++)
            send_point((k < 6) ? dir_range[k] : $urandom_range(32'h0001_0000, 32'h7FFF_FFFF),
                       k == 0 || k == 5);

        // grid shrunk below the current index, clamped sizes, new starts mid-scan,
        // inverted limits
        drain();
        write_reg(lsc_pkg::REG_H_START, 32'h3FFF_FFFF);
        write_reg(lsc_pkg::REG_H_STEP,  32'h8000_0000);
        write_reg(lsc_pkg::REG_V_START, 32'hBFFF_FFFF);
        write_reg(lsc_pkg::REG_V_STEP,  32'h7FFF_FFFF);
        write_reg(lsc_pkg::REG_COLS,    32'hFFFF_F000);
        write_reg(lsc_pkg::REG_ROWS,    32'hFFFF_FFFF);
        write_reg(lsc_pkg::REG_MIN_RNG, 32'h8000_0000);
        write_reg(lsc_pkg::REG_MAX_RNG, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 1'b0);
        send_point($urandom, 1'b0);

        random_sent = 0;
        burst_left  = $urandom_range(1, 40);
        while (random_sent < RANDOM_POINTS) begin
            drain();
            reconfigure();
            grid_points = grid_cols * grid_rows;
            grid_pos    = 0;
            phase_len   = $urandom_range(30, 120);
            well_formed = $urandom_range(0, 99) < 80;
            for (int k = 0; k < phase_len && random_sent < RANDOM_POINTS; k++) begin
                if (well_formed)
                    scan_flag = (k == 0) || (grid_pos == 0 && $urandom_range(0, 1) == 1);
                else
                    scan_flag = ($urandom_range(0, 7) == 0);
                send_point(pick_range(), scan_flag);
                random_sent++;
                if (scan_flag)
                    grid_pos = 0;
                grid_pos++;
                if (grid_pos >= grid_points)
                    grid_pos = 0;
                burst_left--;
                if (burst_left == 0) begin
                    pause_sender($urandom_range(1, 12));
                    burst_left = $urandom_range(1, 40);
                end
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/lsc_pkg.sv
rtl/core/lsc_regs.sv
rtl/core/lsc_cordic.sv
rtl/core/lsc_datapath.sv
rtl/core/lsc_ctrl.sv
rtl/core/lidar_spherical_to_cartesian_top.sv
test/lsc_point_checker.sv
test/tb_lidar_spherical_to_cartesian_top.sv
